### hw/rtl/cedge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, register indexes and sizing constants of the compass edge filter.
package cedge_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int IN_ROW_W   = 16;
  localparam int PIX_W      = 8;
  localparam int KERN_W     = 24;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_TOP_W  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_TOP_H  = DIM_W'(MAX_HEIGHT);

  localparam logic [DIM_W-1:0]  WIDTH_RESET       = DIM_W'(1024);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET      = DIM_W'(1024);
  localparam logic [KERN_W-1:0] KERN_TOP_RESET    = KERN_W'(65791);
  localparam logic [KERN_W-1:0] KERN_MIDDLE_RESET = KERN_W'(131326);
  localparam logic [KERN_W-1:0] KERN_BOTTOM_RESET = KERN_W'(65791);

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_IMAGE_WIDTH  = 3'd0;
  localparam reg_idx_t REG_IMAGE_HEIGHT = 3'd1;
  localparam reg_idx_t REG_KERNEL_TOP   = 3'd2;
  localparam reg_idx_t REG_KERNEL_MID   = 3'd3;
  localparam reg_idx_t REG_KERNEL_BOT   = 3'd4;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } req_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_end;
  } rsp_item_t;

  // Which taps of the window lie inside the frame, plus the end-of-frame mark.
  typedef struct packed {
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
    logic frame_end;
  } tap_ctl_t;

  typedef logic signed [16:0] prod_t;
  typedef logic signed [18:0] row_sum_t;
  typedef logic signed [20:0] total_t;

endpackage

`default_nettype wire

### hw/rtl/compass_edge_conv3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming 3x3 compass edge filter: line memory, window, multiply and sum pipeline.
// One request per clock unless the output stalls; one line memory read and write per cycle.
//   A result passes the line read, window, product, sum and output registers after the
//   request that completes its window is accepted; it arrives one row plus one pixel later.
// Reset clears counters, pipeline valids and the window and loads the
//   register defaults; the line memory is not cleared and needs no clearing pass.

module compass_edge_conv3x3
  import cedge_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  wire req_item_t     req_data,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output rsp_item_t          rsp_data,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [APB_AW-1:0]   paddr,
  input  wire [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  // Frame size is used clamped to the range the line memory supports.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] top);
    if (v < DIM_MIN) begin
      return DIM_MIN;
    end else if (v > top) begin
      return top;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [KERN_W-1:0] kernel_row_top;
  logic [KERN_W-1:0] kernel_row_middle;
  logic [KERN_W-1:0] kernel_row_bottom;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= WIDTH_RESET;
      image_height      <= HEIGHT_RESET;
      kernel_row_top    <= KERN_TOP_RESET;
      kernel_row_middle <= KERN_MIDDLE_RESET;
      kernel_row_bottom <= KERN_BOTTOM_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  image_width       <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height      <= pwdata[DIM_W-1:0];
        REG_KERNEL_TOP:   kernel_row_top    <= pwdata[KERN_W-1:0];
        REG_KERNEL_MID:   kernel_row_middle <= pwdata[KERN_W-1:0];
        REG_KERNEL_BOT:   kernel_row_bottom <= pwdata[KERN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, image_width};
      REG_IMAGE_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, image_height};
      REG_KERNEL_TOP:   prdata = {{(APB_DW-KERN_W){1'b0}}, kernel_row_top};
      REG_KERNEL_MID:   prdata = {{(APB_DW-KERN_W){1'b0}}, kernel_row_middle};
      REG_KERNEL_BOT:   prdata = {{(APB_DW-KERN_W){1'b0}}, kernel_row_bottom};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves when the one after it is empty or
  // moving, so bubbles collapse and a waiting result does not block requests
  // while there is room behind it.
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic rsp_en, s4_en, s3_en, s2_en, s1_en;
  logic accept, load_s1;

  assign rsp_en    = !rsp_valid || rsp_ready;
  assign s4_en     = !s4_valid || rsp_en;
  assign s3_en     = !s3_valid || s4_en;
  assign s2_en     = !s2_valid || s3_en;
  assign s1_en     = !s1_valid || s2_en;
  assign req_ready = s1_en;
  assign accept    = req_valid && req_ready;

  // ---------------------------------------------------------------------------
  // Stage A: position bookkeeping on the accepted request. All counter updates
  // happen here, so the later stages only carry flags and data.
  // ---------------------------------------------------------------------------
  logic [IN_ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]    in_column, in_column_next;
  logic [DIM_W-1:0]    out_row, out_row_next;
  logic [COL_W-1:0]    out_column, out_column_next;

  logic [DIM_W-1:0]    width_eff, height_eff;
  logic                is_flush, idle_flush, past_end, emit;
  logic signed [16:0]  row_diff;
  logic signed [28:0]  span_rows;
  logic [29:0]         pos_rel;
  logic [DIM_W-1:0]    in_col_inc;
  logic [DIM_W:0]      out_row_inc;
  logic [DIM_W-1:0]    out_col_inc;
  logic [PIX_W-1:0]    px_value;
  tap_ctl_t            ctl_a;

  assign width_eff  = clamp_dim(image_width, DIM_TOP_W);
  assign height_eff = clamp_dim(image_height, DIM_TOP_H);

  always_comb begin
    is_flush   = (req_data.kind == KIND_FLUSH);
    idle_flush = is_flush && (in_row == '0) && (in_column == '0);

    // The frame is fully in once row*width + column reaches height*width.
    // Checked as (row - height) * width + column >= 0 with one multiplier.
    row_diff  = $signed({1'b0, in_row}) - $signed({{(17-DIM_W){1'b0}}, height_eff});
    span_rows = row_diff * $signed({1'b0, width_eff});
    pos_rel   = {span_rows[28], span_rows} + {{(30-COL_W){1'b0}}, in_column};
    past_end  = !pos_rel[29];

    px_value = (is_flush || past_end) ? '0 : req_data.pixel;

    // An output becomes due once the window reaches one row plus one pixel in.
    emit = (in_row >= IN_ROW_W'(2)) || ((in_row == IN_ROW_W'(1)) && (in_column != '0));

    in_col_inc = {{(DIM_W-COL_W){1'b0}}, in_column} + DIM_W'(1);
    in_row_next = in_row;
    if (in_col_inc >= width_eff) begin
      in_column_next = '0;
      if (in_row != '1) begin
        in_row_next = in_row + IN_ROW_W'(1);
      end
    end else begin
      in_column_next = in_col_inc[COL_W-1:0];
    end

    out_row_inc = {1'b0, out_row} + (DIM_W+1)'(1);
    out_col_inc = {{(DIM_W-COL_W){1'b0}}, out_column} + DIM_W'(1);

    ctl_a.top_ok    = (out_row != '0);
    ctl_a.bottom_ok = !(out_row_inc >= {1'b0, height_eff});
    ctl_a.left_ok   = (out_column != '0);
    ctl_a.right_ok  = !(out_col_inc >= width_eff);
    ctl_a.frame_end = !ctl_a.bottom_ok && !ctl_a.right_ok;

    out_row_next    = out_row;
    out_column_next = out_column;
    if (emit) begin
      if (ctl_a.frame_end) begin
        // Last output of the frame: every position counter starts over.
        in_row_next     = '0;
        in_column_next  = '0;
        out_row_next    = '0;
        out_column_next = '0;
      end else if (!ctl_a.right_ok) begin
        out_column_next = '0;
        out_row_next    = out_row_inc[DIM_W-1:0];
      end else begin
        out_column_next = out_col_inc[COL_W-1:0];
      end
    end
  end

  // A flush with no frame in progress is taken and dropped.
  assign load_s1 = accept && !idle_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row     <= '0;
      in_column  <= '0;
      out_row    <= '0;
      out_column <= '0;
    end else if (load_s1) begin
      in_row     <= in_row_next;
      in_column  <= in_column_next;
      out_row    <= out_row_next;
      out_column <= out_column_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memory. One entry per column holds {upper, middle} pixels.
  // The read is issued on accept; the write-back (middle moves up, the new
  // pixel becomes middle) happens when the request leaves this stage. Two
  // requests in a row normally use different columns; the bypass covers the
  // frame restart, where the next column can equal the one being written.
  // ---------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd;
  logic [2*PIX_W-1:0] fwd_data;
  logic [2*PIX_W-1:0] line_col;
  logic [2*PIX_W-1:0] wr_data;
  logic               rd_fwd;
  logic               wr_en;

  logic [PIX_W-1:0]   s1_value;
  logic [COL_W-1:0]   s1_col;
  logic               s1_emit;
  tap_ctl_t           s1_ctl;

  assign wr_en    = s1_valid && s2_en;
  assign line_col = rd_fwd ? fwd_data : line_rd;
  assign wr_data  = {line_col[PIX_W-1:0], s1_value};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_col] <= wr_data;
    end
    if (load_s1) begin
      line_rd  <= line_mem[in_column];
      rd_fwd   <= wr_en && (s1_col == in_column);
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= load_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && load_s1) begin
      s1_value <= px_value;
      s1_col   <= in_column;
      s1_emit  <= emit;
      s1_ctl   <= ctl_a;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the 3x3 window. It shifts left on every request and takes the new
  // right column: upper line, middle line, incoming pixel. Since the window
  // only moves when stage 2 moves, it stays put for a stalled output.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win [3][3];
  tap_ctl_t         s2_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= line_col[2*PIX_W-1:PIX_W];
      win[1][2] <= line_col[PIX_W-1:0];
      win[2][2] <= s1_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_ctl <= s1_ctl;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: nine pixel-by-weight products. Taps outside the frame are forced
  // to zero, which is the zero padding at the borders.
  // ---------------------------------------------------------------------------
  logic [KERN_W-1:0] kern_rows [3];
  prod_t             prod_next [3][3];
  prod_t             prod [3][3];
  logic              s3_frame_end;

  assign kern_rows[0] = kernel_row_top;
  assign kern_rows[1] = kernel_row_middle;
  assign kern_rows[2] = kernel_row_bottom;

  always_comb begin
    logic [PIX_W-1:0] tap_px;
    logic [PIX_W-1:0] tap_wt;
    logic             row_en;
    logic             col_en;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        row_en = (r == 0) ? s2_ctl.top_ok  : ((r == 2) ? s2_ctl.bottom_ok : 1'b1);
        col_en = (c == 0) ? s2_ctl.left_ok : ((c == 2) ? s2_ctl.right_ok  : 1'b1);
        tap_px = (row_en && col_en) ? win[r][c] : '0;
        tap_wt = kern_rows[r][PIX_W*c +: PIX_W];
        prod_next[r][c] = $signed({9'd0, tap_px}) * $signed({{9{tap_wt[PIX_W-1]}}, tap_wt});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      prod         <= prod_next;
      s3_frame_end <= s2_ctl.frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: one sum per kernel row.
  // ---------------------------------------------------------------------------
  row_sum_t row_sum [3];
  logic     s4_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] <= row_sum_t'(prod[r][0]) + row_sum_t'(prod[r][1])
                    + row_sum_t'(prod[r][2]);
      end
      s4_frame_end <= s3_frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: total, then magnitude. Only the low byte of |sum| is kept,
  // and the low byte of a negation depends only on the low byte of the sum.
  // ---------------------------------------------------------------------------
  total_t           total;
  logic [PIX_W-1:0] edge_abs;

  always_comb begin
    total    = total_t'(row_sum[0]) + total_t'(row_sum[1]) + total_t'(row_sum[2]);
    edge_abs = total[20] ? (PIX_W'(0) - total[PIX_W-1:0]) : total[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_en) begin
      rsp_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_en && s4_valid) begin
      rsp_data.edge_value <= edge_abs;
      rsp_data.frame_end  <= s4_frame_end;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cedge_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the compass edge filter and their bind to the top level.
module cedge_checker
  import cedge_pkg::*;
(
  input wire               clk,
  input wire               rst,
  input wire               req_valid,
  input wire               req_ready,
  input wire req_item_t    req_data,
  input wire               rsp_valid,
  input wire               rsp_ready,
  input wire rsp_item_t    rsp_data,
  input wire               psel,
  input wire               penable,
  input wire               pwrite,
  input wire [APB_AW-1:0]  paddr,
  input wire [APB_DW-1:0]  pwdata,
  input wire [APB_DW-1:0]  prdata,
  input wire               pready
);

  // A result that is not taken stays in place.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // With the output empty, the whole pipeline can move, so requests are taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with an empty output");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result present right after reset");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

  // The top kernel row, once written, reads back unchanged.
  a_kernel_readback: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(psel && penable && pwrite && paddr[APB_AW-1:2] == REG_KERNEL_TOP)
      && paddr[APB_AW-1:2] == REG_KERNEL_TOP
    |-> prdata == {{(APB_DW-KERN_W){1'b0}}, $past(pwdata[KERN_W-1:0])})
    else $error("kernel row readback mismatch");

endmodule

bind compass_edge_conv3x3 cedge_checker u_cedge_checker (.*);

`default_nettype wire

### bench/tb_compass_edge_conv3x3.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 compass edge filter, with its own pixel-stream predictor.

module tb_compass_edge_conv3x3;
  import cedge_pkg::*;

  // The outer ring of the east compass mask, clockwise from the top-left corner.
  // Rotating this ring by one step turns the mask by 45 degrees.
  localparam int COMPASS_RING [8] = '{-1, 0, 1, 2, 1, 0, -1, -2};
  localparam int RUN_LIMIT_NS = 10_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              req_valid = 1'b0;
  logic              req_ready;
  req_item_t         req_data  = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_item_t         rsp_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Percent of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  // Requests that moved the frame forward; ignored flushes are not counted.
  int steps_taken = 0;

  // Predictor copy of the register file.
  logic [DIM_W-1:0]  cfg_width  = WIDTH_RESET;
  logic [DIM_W-1:0]  cfg_height = HEIGHT_RESET;
  logic [KERN_W-1:0] cfg_kern [3] = '{KERN_TOP_RESET, KERN_MIDDLE_RESET, KERN_BOTTOM_RESET};

  // Predictor copy of the line memories, the window and the position counters.
  logic [PIX_W-1:0]    upper_row  [MAX_WIDTH];
  logic [PIX_W-1:0]    middle_row [MAX_WIDTH];
  logic [PIX_W-1:0]    win_pix    [9];
  logic [IN_ROW_W-1:0] in_row  = '0;
  logic [DIM_W-1:0]    in_col  = '0;
  logic [DIM_W-1:0]    out_row = '0;
  logic [DIM_W-1:0]    out_col = '0;

  // Results still owed by the block, oldest first.
  rsp_item_t pending_edges [$];
  rsp_item_t want_edge;

  compass_edge_conv3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // The receiver stalls at random; the stall decision changes on the falling edge.
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Out-of-range frame sizes saturate to the supported range.
  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int top);
    if (v < 2) return 2;
    if (v > top) return top;
    return int'(v);
  endfunction

  // Mostly uniform pixels, with black and white showing up often.
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Advances the predictor by one accepted request and queues the result it causes.
  function automatic void predict_edge(input req_item_t rq);
    int w;
    int h;
    int sum;
    int r;
    int c;
    logic [PIX_W-1:0] value;
    logic signed [7:0] wt;
    logic window_full;
    rsp_item_t got;

    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    value = rq.pixel;

    // A flush with no frame under way does nothing at all.
    if (rq.kind == KIND_FLUSH && in_row == 0 && in_col == 0) return;
    steps_taken++;

    // Flushes, and pixels past the end of the frame, feed zeros into the window.
    if (rq.kind == KIND_FLUSH || longint'(in_row) * w + in_col >= longint'(h) * w)
      value = '0;

    for (r = 0; r < 3; r++) begin
      win_pix[r*3+0] = win_pix[r*3+1];
      win_pix[r*3+1] = win_pix[r*3+2];
    end
    if (in_col < MAX_WIDTH) begin
      win_pix[2] = upper_row[in_col];
      win_pix[5] = middle_row[in_col];
      upper_row[in_col] = middle_row[in_col];
      middle_row[in_col] = value;
    end else begin
      win_pix[2] = '0;
      win_pix[5] = '0;
    end
    win_pix[8] = value;

    // The first output needs one full row plus one pixel of input.
    window_full = (in_row >= 2) || (in_row == 1 && in_col >= 1);

    in_col = in_col + 1'b1;
    if (in_col >= w) begin
      in_col = '0;
      if (in_row < 16'hFFFF) in_row = in_row + 1'b1;
    end

    if (!window_full) return;

    // Taps that fall outside the frame are skipped, which is zero padding.
    sum = 0;
    for (r = 0; r < 3; r++) begin
      if ((r == 0 && out_row == 0) || (r == 2 && int'(out_row) + 1 >= h)) continue;
      for (c = 0; c < 3; c++) begin
        if ((c == 0 && out_col == 0) || (c == 2 && int'(out_col) + 1 >= w)) continue;
        wt = cfg_kern[r][8*c +: 8];
        sum += int'(win_pix[r*3+c]) * int'(wt);
      end
    end
    if (sum < 0) sum = -sum;
    got.edge_value = sum[7:0];

    if (int'(out_row) + 1 >= h && int'(out_col) + 1 >= w) begin
      got.frame_end = 1'b1;
      in_row  = '0;
      in_col  = '0;
      out_row = '0;
      out_col = '0;
    end else begin
      got.frame_end = 1'b0;
      if (int'(out_col) + 1 >= w) begin
        out_col = '0;
        out_row = out_row + 1'b1;
      end else begin
        out_col = out_col + 1'b1;
      end
    end
    pending_edges.push_back(got);
  endfunction

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_edges.size() == 0) begin
        $display("%0t: result with none expected, got edge_value %0d frame_end %0b",
                 $time, rsp_data.edge_value, rsp_data.frame_end);
        mismatch_count++;
      end else begin
        want_edge = pending_edges.pop_front();
        if (rsp_data.edge_value !== want_edge.edge_value) begin
          $display("%0t: edge_value mismatch, expected %0d, got %0d",
                   $time, want_edge.edge_value, rsp_data.edge_value);
          mismatch_count++;
        end
        if (rsp_data.frame_end !== want_edge.frame_end) begin
          $display("%0t: frame_end mismatch, expected %0b, got %0b",
                   $time, want_edge.frame_end, rsp_data.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  // Sends one request: random hold-off first, then valid stays up until it is taken.
  // Called and returns just after a falling edge.
  task automatic send_req(input logic kind, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_data.kind  = kind;
    req_data.pixel = pix;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_edge(req_data);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  // Waits until every predicted result has arrived, then lets the pipeline settle,
  // since the last requests may still be in flight without causing a result.
  task automatic wait_drained();
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes one register over APB while the block is idle, then reads it back.
  task automatic set_reg(input reg_idx_t idx, input logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] stored;
    wait_drained();
    case (idx)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: stored = val & 32'h0000_07FF;
      default: stored = val & 32'h00FF_FFFF;
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  cfg_width   = stored[DIM_W-1:0];
      REG_IMAGE_HEIGHT: cfg_height  = stored[DIM_W-1:0];
      REG_KERNEL_TOP:   cfg_kern[0] = stored[KERN_W-1:0];
      REG_KERNEL_MID:   cfg_kern[1] = stored[KERN_W-1:0];
      REG_KERNEL_BOT:   cfg_kern[2] = stored[KERN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored) begin
      $display("%0t: register %0d readback mismatch, expected %h, got %h",
               $time, idx, stored, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Sends one pixel request per position of the frame; some become early flushes.
  task automatic send_frame(input int flush_pct);
    int n;
    int i;
    n = clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < flush_pct) send_req(KIND_FLUSH, rand_pixel());
      else send_req(KIND_PIXEL, rand_pixel());
    end
  endtask

  // Keeps feeding requests until the frame has ended. Past the last pixel,
  // pixel requests act just like flushes.
  task automatic drain_frame(input int pixel_pct);
    while (in_row != 0 || in_col != 0) begin
      send_req(($urandom_range(99) < pixel_pct) ? KIND_PIXEL : KIND_FLUSH, rand_pixel());
    end
  endtask

  task automatic test_directed_cases();
    int i;
    // A flush with no frame open must be dropped without a result.
    send_req(KIND_FLUSH, 8'hFF);

    // Width 0 and height 1 saturate to a 2x2 frame. The weights sit at both
    // ends of the signed range, so the sums wrap modulo 256.
    set_reg(REG_IMAGE_WIDTH, 32'd0);
    set_reg(REG_IMAGE_HEIGHT, 32'd1);
    set_reg(REG_KERNEL_TOP, 32'h007F_807F);
    set_reg(REG_KERNEL_MID, 32'h0080_7F80);
    set_reg(REG_KERNEL_BOT, 32'h007F_807F);
    send_req(KIND_PIXEL, 8'hFF);
    send_req(KIND_PIXEL, 8'hFF);
    send_req(KIND_PIXEL, 8'h00);
    send_req(KIND_PIXEL, 8'hFF);
    drain_frame(0);

    // A 3x3 frame with the east mask. The center pixel arrives as a flush and so
    // counts as zero, and the frame is drained with pixels instead of flushes.
    set_reg(REG_IMAGE_WIDTH, 32'd3);
    set_reg(REG_IMAGE_HEIGHT, 32'd3);
    set_reg(REG_KERNEL_TOP, 32'(KERN_TOP_RESET));
    set_reg(REG_KERNEL_MID, 32'(KERN_MIDDLE_RESET));
    set_reg(REG_KERNEL_BOT, 32'(KERN_BOTTOM_RESET));
    for (i = 0; i < 9; i++) begin
      if (i == 4) send_req(KIND_FLUSH, 8'h5A);
      else send_req(KIND_PIXEL, (i % 2 == 1) ? 8'hFF : 8'h80);
    end
    drain_frame(100);
  endtask

  // Geometry changed in the middle of a frame: the sender stops until every result
  // so far has come out, then the width shrinks, the height grows and the weights change.
  task automatic test_midframe_change();
    int i;
    set_reg(REG_IMAGE_WIDTH, 32'd6);
    set_reg(REG_IMAGE_HEIGHT, 32'd4);
    set_reg(REG_KERNEL_TOP, 32'h0001_00FF);
    set_reg(REG_KERNEL_MID, 32'h0002_00FE);
    set_reg(REG_KERNEL_BOT, 32'h0001_00FF);
    for (i = 0; i < 10; i++) send_req(KIND_PIXEL, rand_pixel());
    wait_drained();
    set_reg(REG_IMAGE_WIDTH, 32'd3);
    set_reg(REG_IMAGE_HEIGHT, 32'd5);
    set_reg(REG_KERNEL_TOP, 32'h00FE_FFFF);
    set_reg(REG_KERNEL_MID, 32'h00FF_0001);
    set_reg(REG_KERNEL_BOT, 32'h0001_0102);
    drain_frame(50);
  endtask

  // The largest sizes the block allows. A width written as 2047 saturates to 1024:
  // one full row and a few pixels of the next go in, so every line memory column
  // is used, then the width drops to four and the frame is drained. A height
  // written as 2047 saturates to 1024 rows; a few rows go in and the frame is cut
  // short by lowering the height to three.
  task automatic test_extreme_sizes();
    int i;
    set_reg(REG_IMAGE_WIDTH, 32'd2047);
    set_reg(REG_IMAGE_HEIGHT, 32'd2);
    set_reg(REG_KERNEL_TOP, $urandom);
    set_reg(REG_KERNEL_MID, $urandom);
    set_reg(REG_KERNEL_BOT, $urandom);
    for (i = 0; i < MAX_WIDTH + 6; i++) send_req(KIND_PIXEL, rand_pixel());
    wait_drained();
    set_reg(REG_IMAGE_WIDTH, 32'd4);
    drain_frame(0);
    set_reg(REG_IMAGE_WIDTH, 32'd2);
    set_reg(REG_IMAGE_HEIGHT, 32'd2047);
    for (i = 0; i < 30; i++) send_req(KIND_PIXEL, rand_pixel());
    wait_drained();
    set_reg(REG_IMAGE_HEIGHT, 32'd3);
    drain_frame(50);
  endtask

  // Whole frames of random size and content, each with a compass mask or random
  // weights, a little noise inside and a drain of mixed flushes and stray pixels.
  task automatic test_random_frames(input int target);
    int start;
    int w;
    int h;
    int rot;
    int i;
    logic [7:0] ring [8];
    logic [KERN_W-1:0] rows [3];
    start = steps_taken;
    while (steps_taken - start < target) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
      h = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
      // Now and then a size below the minimum, which saturates to two.
      if ($urandom_range(15) == 0) w = $urandom_range(1);
      if ($urandom_range(15) == 0) h = $urandom_range(1);

      if ($urandom_range(1) == 1) begin
        rot = $urandom_range(7);
        for (i = 0; i < 8; i++) ring[i] = 8'(COMPASS_RING[(i + rot) % 8]);
        rows[0] = {ring[2], ring[1], ring[0]};
        rows[1] = {ring[3], 8'h00, ring[7]};
        rows[2] = {ring[4], ring[5], ring[6]};
      end else begin
        for (i = 0; i < 3; i++) begin
          case ($urandom_range(7))
            0: rows[i] = 24'h80_8080;
            1: rows[i] = 24'h7F_7F7F;
            default: rows[i] = 24'($urandom);
          endcase
        end
      end

      // Bits above each register's width carry junk and must be dropped.
      set_reg(REG_IMAGE_WIDTH, {21'($urandom), 11'(w)});
      set_reg(REG_IMAGE_HEIGHT, {21'($urandom), 11'(h)});
      set_reg(REG_KERNEL_TOP, {8'($urandom), rows[0]});
      set_reg(REG_KERNEL_MID, {8'($urandom), rows[1]});
      set_reg(REG_KERNEL_BOT, {8'($urandom), rows[2]});

      if ($urandom_range(4) == 0) send_req(KIND_FLUSH, rand_pixel());
      send_frame(4);
      drain_frame(30);
    end
  endtask

  initial begin
    foreach (upper_row[i]) upper_row[i] = '0;
    foreach (middle_row[i]) middle_row[i] = '0;
    foreach (win_pix[i]) win_pix[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Light sender gaps against a receiver that stalls most of the time.
    send_idle_pct = 15;
    recv_idle_pct = 81;
    test_directed_cases();
    test_midframe_change();
    test_random_frames(110);

    // The other way round: a slow sender and a mostly ready receiver.
    send_idle_pct = 81;
    recv_idle_pct = 15;
    test_extreme_sizes();
    test_random_frames(110);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(100);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guards against a hang, such as a result that never comes out.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
